// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// File: design/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg
// Types and constants for the bump allocator with card marking.
// ----------------------------------------------------------------------------
`default_nettype none

package bac_pkg;

   localparam int ADDR_W = 48;
   localparam int SIZE_W = 25;
   localparam int OP_W   = 2;

   // heap and card geometry, both powers of two
   localparam int HEAP_LOG2 = 24;
   localparam int CARD_LOG2 = 9;
   localparam longint unsigned HEAP_BYTES = 64'd1 << HEAP_LOG2;
   localparam longint unsigned CARD_BYTES = 64'd1 << CARD_LOG2;
   localparam int CARD_W = HEAP_LOG2 - CARD_LOG2;
   localparam int CARD_COUNT = 1 << CARD_W;

   // card store rows: several dirty bits per RAM word
   localparam int ROW_LOG2 = 6;
   localparam int ROW_BITS = 1 << ROW_LOG2;
   localparam int ROW_AW   = CARD_W - ROW_LOG2;
   localparam int ROWS     = CARD_COUNT / ROW_BITS;

   typedef logic [ROW_BITS-1:0] row_type;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_MARK  = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CALC = 7'b0000010,
      ST_BASE = 7'b0000100,
      ST_RD   = 7'b0001000,
      ST_MOD  = 7'b0010000,
      ST_CLR  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic              subtract;
      logic [ADDR_W-1:0] limit;
   } unit_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] sum;
      logic              below;
   } unit_rsp_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ROW_AW-1:0] addr;
      row_type           wdata;
   } ram_req_type;

endpackage

`default_nettype wire

// File: design/bump_allocator_card_marking.sv
// ----------------------------------------------------------------------------
// bump_allocator_card_marking
// Bump-pointer heap allocator with a card-table write barrier.
// ----------------------------------------------------------------------------
// One request is in flight at a time; req_stall is low only while idle. From
// accept to result, allocate runs through the calc, base, read and modify
// states, mark and query of an in-heap address through calc, read and modify,
// zero-size or exhausted allocate and out-of-heap mark or query through calc
// only, and clear-all through a sweep of the card store, one row of 64 cards a
// cycle. The paths come from the single shared adder, which does the bump and
// the base add in separate cycles, and from the single-port card RAM, whose
// registered read is followed by a write for a mark. After reset the same
// sweep runs before the first request is taken; csr writes are taken at any time.
`default_nettype none
`include "assert_macros.svh"

module bump_allocator_card_marking (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [47:0] csr_wr_data,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_opcode,
   input  wire  [47:0] req_address,
   input  wire  [24:0] req_alloc_size,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [47:0] rsp_block_address,
   output logic        rsp_card_dirty,
   output logic        rsp_exhausted
);

   bac_pkg::state_type state_ff;
   bac_pkg::op_type    opcode_ff;
   logic [bac_pkg::ADDR_W-1:0] heap_base_ff;
   logic [bac_pkg::ADDR_W-1:0] addr_ff;
   logic [bac_pkg::SIZE_W-1:0] size_ff;
   logic [bac_pkg::SIZE_W-1:0] offset_ff;
   logic [bac_pkg::SIZE_W-1:0] sum_ff;
   logic [bac_pkg::CARD_W-1:0] card_ff;
   logic [bac_pkg::ROW_AW-1:0] clr_row_ff;
   logic                       clr_rsp_ff;
   logic [bac_pkg::ADDR_W-1:0] res_block_ff;
   logic                       res_dirty_ff;
   logic                       res_exh_ff;
   logic                       rsp_valid_ff;
   logic [bac_pkg::ADDR_W-1:0] rsp_block_ff;
   logic                       rsp_dirty_ff;
   logic                       rsp_exh_ff;

   bac_pkg::unit_req_type unit_req;
   bac_pkg::unit_rsp_type unit_rsp;
   bac_pkg::ram_req_type  ram_req;
   bac_pkg::row_type      ram_rdata;
   logic                  out_room;
   logic [bac_pkg::ROW_LOG2-1:0] bit_sel;

   bac_addr_unit u_unit (
      .req (unit_req),
      .rsp (unit_rsp)
   );

   bac_card_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   assign bit_sel  = card_ff[bac_pkg::ROW_LOG2-1:0];
   assign out_room = !rsp_valid_ff || !rsp_stall;

   // shared adder operand selection
   always_comb begin
      unit_req = '0;
      if (state_ff == bac_pkg::ST_CALC) begin
         if (opcode_ff == bac_pkg::OP_ALLOC) begin
            unit_req.a        = bac_pkg::ADDR_W'(offset_ff);
            unit_req.b        = bac_pkg::ADDR_W'(size_ff);
            unit_req.subtract = 1'b0;
            unit_req.limit    = bac_pkg::ADDR_W'(bac_pkg::HEAP_BYTES + 64'd1);
         end else begin
            unit_req.a        = addr_ff;
            unit_req.b        = heap_base_ff;
            unit_req.subtract = 1'b1;
            unit_req.limit    = bac_pkg::ADDR_W'(bac_pkg::HEAP_BYTES);
         end
      end else begin
         unit_req.a        = heap_base_ff;
         unit_req.b        = bac_pkg::ADDR_W'(offset_ff);
         unit_req.subtract = 1'b0;
         unit_req.limit    = '0;
      end
   end

   // card store port
   always_comb begin
      ram_req       = '0;
      ram_req.addr  = card_ff[bac_pkg::CARD_W-1:bac_pkg::ROW_LOG2];
      ram_req.wdata = ram_rdata | (bac_pkg::row_type'(1) << bit_sel);
      case (state_ff)
         bac_pkg::ST_RD: begin
            ram_req.en = 1'b1;
         end
         bac_pkg::ST_MOD: begin
            ram_req.en = (opcode_ff != bac_pkg::OP_QUERY);
            ram_req.we = 1'b1;
         end
         bac_pkg::ST_CLR: begin
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = clr_row_ff;
            ram_req.wdata = '0;
         end
         default: begin
            ram_req.en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
      end else if (csr_wr_en) begin
         heap_base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bac_pkg::ST_CLR;
         clr_row_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != bac_pkg::ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            bac_pkg::ST_IDLE: begin
               if (req_valid) begin
                  opcode_ff <= bac_pkg::op_type'(req_opcode);
                  addr_ff   <= req_address;
                  size_ff   <= req_alloc_size;
                  state_ff  <= bac_pkg::ST_CALC;
               end
            end
            bac_pkg::ST_CALC: begin
               res_block_ff <= '0;
               res_dirty_ff <= 1'b0;
               res_exh_ff   <= (opcode_ff == bac_pkg::OP_ALLOC) && (size_ff != '0) &&
                               !unit_rsp.below;
               case (opcode_ff)
                  bac_pkg::OP_ALLOC: begin
                     card_ff <= offset_ff[bac_pkg::HEAP_LOG2-1:bac_pkg::CARD_LOG2];
                     sum_ff  <= unit_rsp.sum[bac_pkg::SIZE_W-1:0];
                     if (size_ff == '0) begin
                        state_ff <= bac_pkg::ST_DONE;
                     end else if (!unit_rsp.below) begin
                        state_ff <= bac_pkg::ST_DONE;
                     end else begin
                        state_ff <= bac_pkg::ST_BASE;
                     end
                  end
                  bac_pkg::OP_MARK, bac_pkg::OP_QUERY: begin
                     card_ff <= unit_rsp.sum[bac_pkg::HEAP_LOG2-1:bac_pkg::CARD_LOG2];
                     // drop addresses outside the heap
                     if (unit_rsp.below) begin
                        state_ff <= bac_pkg::ST_RD;
                     end else begin
                        state_ff <= bac_pkg::ST_DONE;
                     end
                  end
                  default: begin
                     clr_row_ff <= '0;
                     clr_rsp_ff <= 1'b1;
                     state_ff   <= bac_pkg::ST_CLR;
                  end
               endcase
            end
            bac_pkg::ST_BASE: begin
               res_block_ff <= unit_rsp.sum;
               offset_ff    <= sum_ff;
               state_ff     <= bac_pkg::ST_RD;
            end
            bac_pkg::ST_RD: begin
               state_ff <= bac_pkg::ST_MOD;
            end
            bac_pkg::ST_MOD: begin
               if (opcode_ff == bac_pkg::OP_QUERY) begin
                  res_dirty_ff <= ram_rdata[bit_sel];
               end
               state_ff <= bac_pkg::ST_DONE;
            end
            bac_pkg::ST_CLR: begin
               clr_row_ff <= clr_row_ff + bac_pkg::ROW_AW'(1);
               if (clr_row_ff == bac_pkg::ROW_AW'(bac_pkg::ROWS - 1)) begin
                  state_ff <= clr_rsp_ff ? bac_pkg::ST_DONE : bac_pkg::ST_IDLE;
               end
            end
            bac_pkg::ST_DONE: begin
               // hold until the output register frees up
               if (out_room) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_block_ff <= res_block_ff;
                  rsp_dirty_ff <= res_dirty_ff;
                  rsp_exh_ff   <= res_exh_ff;
                  state_ff     <= bac_pkg::ST_IDLE;
               end
            end
            default: begin
               state_ff <= bac_pkg::ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != bac_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_block_ff;
   assign rsp_card_dirty    = rsp_dirty_ff;
   assign rsp_exhausted     = rsp_exh_ff;

   `ASSERT_ALWAYS(a_offset_in_heap, clock, reset,
      {23'd0, offset_ff} <= bac_pkg::SIZE_W'(bac_pkg::HEAP_BYTES))
   `ASSERT_IMPLIES(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == bac_pkg::ST_DONE))
   `ASSERT_IMPLIES(a_offset_moves_in_base, clock, reset,
      !$past(reset) && (offset_ff != $past(offset_ff)), $past(state_ff == bac_pkg::ST_BASE))
   `ASSERT_IMPLIES(a_exhausted_no_block, clock, reset,
      rsp_valid_ff && rsp_exh_ff, (rsp_block_ff == '0) && !rsp_dirty_ff)
   `ASSERT_IMPLIES(a_store_busy_stalls, clock, reset,
      ram_req.en, req_stall)

endmodule

`default_nettype wire

// File: design/bac_addr_unit.sv
// ----------------------------------------------------------------------------
// bac_addr_unit
// Shared 48-bit add/subtract with an unsigned compare against a limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bac_addr_unit (
   input  wire  bac_pkg::unit_req_type req,
   output       bac_pkg::unit_rsp_type rsp
);

   logic [bac_pkg::ADDR_W-1:0] sum;

   always_comb begin
      if (req.subtract) begin
         sum = req.a - req.b;
      end else begin
         sum = req.a + req.b;
      end
      rsp.sum   = sum;
      rsp.below = (sum < req.limit);
   end

endmodule

`default_nettype wire

// File: design/bac_card_ram.sv
// ----------------------------------------------------------------------------
// bac_card_ram
// Single-port card store, one row of dirty bits per word, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bac_card_ram (
   input  wire                   clock,
   input  wire  bac_pkg::ram_req_type req,
   output       bac_pkg::row_type rdata
);

   bac_pkg::row_type mem [bac_pkg::ROWS];
   bac_pkg::row_type rdata_ff;

   always_ff @(posedge clock) begin
      if (req.en) begin
         if (req.we) begin
            mem[req.addr] <= req.wdata;
         end else begin
            rdata_ff <= mem[req.addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
